// File: rtl/sftd_pkg.sv
package sftd_pkg;

  // Framing
  localparam logic [7:0] SYNC_BYTE     = 8'h80;
  localparam int unsigned SYNC_LEN     = 3;
  localparam int unsigned PAYLOAD_BYTES = 3;

  // Widths of the fixed fields
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PAYLOAD_W  = 24;
  localparam int unsigned CHIP_W     = 3;
  localparam int unsigned INACT_W    = 3;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned TYPE_BIT_W = 5;

  // Payload field positions
  localparam int unsigned CHIP_LSB   = 20;
  localparam int unsigned INACT_LSB  = 14;
  localparam int unsigned INACT_BITS = 5;
  localparam int unsigned START_LSB  = 11;
  localparam int unsigned START_BITS = 4;
  localparam int unsigned OFFS_LSB   = 8;
  localparam int unsigned OFFS_BITS  = 3;
  localparam int unsigned CNT_LSB    = 0;
  localparam int unsigned CNT_BITS   = 8;

  // Output word layout (tdata, lowest bit first)
  localparam int unsigned OUT_DATA_W = 128;

  // Reset values and defaults
  localparam logic [TYPE_BIT_W-1:0] TYPE_BIT_RST = 5'd23;
  localparam int unsigned ACC_WIDTH_DEF = 32;

  typedef enum logic {
    ST_HUNT,
    ST_COLLECT
  } state_e;

  // Ones count of the inactive-chip mask
  function automatic logic [INACT_W-1:0] ones5(input logic [INACT_BITS-1:0] v);
    logic [INACT_W-1:0] n;
    n = '0;
    for (int k = 0; k < INACT_BITS; k++) begin
      n = n + INACT_W'(v[k]);
    end
    return n;
  endfunction

endpackage

// File: rtl/sync_framed_telemetry_deframer_top.sv
// Deframer for framed telemetry arriving as serial bytes, one byte per input word.
// The block hunts for three 0x80 sync bytes in a row, then takes the next three
// bytes (most significant first) as a 24-bit payload, whatever their values.
// Each completed frame yields one output word; all other bytes yield none.
// The payload bit chosen by type_bit (reset 23; 24..31 read as zero) marks a
// health packet, which reloads the inactive-chip count and adds three payload
// fields into wrapping ACC_WIDTH-bit totals, reported as their low 32 bits.
// The decode and accumulator update sit between the input handshake and a single
// output register, so a byte is taken every cycle unless that register is full and
// stalled by the sink.
module sync_framed_telemetry_deframer_top
  import sftd_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Configuration: type_bit
  input  logic                  cfg_we_i,
  input  logic [TYPE_BIT_W-1:0] cfg_wdata_i,

  // Byte input. tdata: [7:0] rx_byte
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,

  // Packet output. tuser: [0] is_health
  // tdata: [2:0] chip_index, [26:3] payload, [29:27] inactive_chips,
  //        [61:30] start_total, [93:62] offset_total, [125:94] count_total, zero above
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  // Control state
  state_e                  state_q, state_d;
  logic [1:0]              sync_run_q, sync_run_d;
  logic [1:0]              byte_cnt_q, byte_cnt_d;
  logic [TYPE_BIT_W-1:0]   type_bit_q;
  logic                    out_valid_q;

  // Data state
  logic [PAYLOAD_W-1:0]    shift_q, shift_d;
  logic [INACT_W-1:0]      inact_q, inact_d;
  logic [ACC_WIDTH-1:0]    start_acc_q, start_acc_d;
  logic [ACC_WIDTH-1:0]    offs_acc_q, offs_acc_d;
  logic [ACC_WIDTH-1:0]    cnt_acc_q, cnt_acc_d;

  // Output register
  logic                    health_q;
  logic [PAYLOAD_W-1:0]    pay_q;
  logic [INACT_W-1:0]      out_inact_q;
  logic [TOTAL_W-1:0]      start_tot_q, offs_tot_q, cnt_tot_q;

  logic                    in_acc;
  logic                    is_sync;
  logic                    frame_done;
  logic [PAYLOAD_W-1:0]    frame_word;
  logic [31:0]             frame_ext;
  logic                    health;

  // Handshake: the output register frees up when the sink takes its word
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_sync       = (s_axis_tdata == SYNC_BYTE);
  assign frame_done    = (state_q == ST_COLLECT) &&
                         (byte_cnt_q == 2'(PAYLOAD_BYTES - 1));

  // Payload as it stands once this byte is shifted in
  assign frame_word = {shift_q[PAYLOAD_W-BYTE_W-1:0], s_axis_tdata};
  assign frame_ext  = {{(32-PAYLOAD_W){1'b0}}, frame_word};
  assign health     = frame_ext[type_bit_q];

  // Next state
  always_comb begin
    state_d = state_q;
    if (in_acc) begin
      unique case (state_q)
        ST_HUNT: begin
          if (is_sync && sync_run_q == 2'(SYNC_LEN - 1)) begin
            state_d = ST_COLLECT;
          end
        end
        ST_COLLECT: begin
          if (frame_done) begin
            state_d = ST_HUNT;
          end
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  // Counters and datapath
  always_comb begin
    sync_run_d  = sync_run_q;
    byte_cnt_d  = byte_cnt_q;
    shift_d     = shift_q;
    inact_d     = inact_q;
    start_acc_d = start_acc_q;
    offs_acc_d  = offs_acc_q;
    cnt_acc_d   = cnt_acc_q;
    if (in_acc) begin
      unique case (state_q)
        ST_HUNT: begin
          byte_cnt_d = '0;
          if (is_sync && sync_run_q != 2'(SYNC_LEN - 1)) begin
            sync_run_d = sync_run_q + 2'd1;
          end else begin
            sync_run_d = '0;
          end
        end
        ST_COLLECT: begin
          sync_run_d = '0;
          shift_d    = frame_word;
          if (frame_done) begin
            byte_cnt_d = '0;
            if (health) begin
              inact_d     = ones5(frame_word[INACT_LSB +: INACT_BITS]);
              start_acc_d = start_acc_q + ACC_WIDTH'(frame_word[START_LSB +: START_BITS]);
              offs_acc_d  = offs_acc_q + ACC_WIDTH'(frame_word[OFFS_LSB +: OFFS_BITS]);
              cnt_acc_d   = cnt_acc_q + ACC_WIDTH'(frame_word[CNT_LSB +: CNT_BITS]);
            end
          end else begin
            byte_cnt_d = byte_cnt_q + 2'd1;
          end
        end
        default: begin
          sync_run_d = '0;
          byte_cnt_d = '0;
        end
      endcase
    end
  end

  // Low 32 bits of each total, zero-extended when the accumulators are narrower
  logic [ACC_WIDTH+TOTAL_W-1:0] start_wide, offs_wide, cnt_wide;
  assign start_wide = {{TOTAL_W{1'b0}}, start_acc_d};
  assign offs_wide  = {{TOTAL_W{1'b0}}, offs_acc_d};
  assign cnt_wide   = {{TOTAL_W{1'b0}}, cnt_acc_d};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      sync_run_q  <= '0;
      byte_cnt_q  <= '0;
      type_bit_q  <= TYPE_BIT_RST;
      out_valid_q <= 1'b0;
      inact_q     <= '0;
      start_acc_q <= '0;
      offs_acc_q  <= '0;
      cnt_acc_q   <= '0;
    end else begin
      state_q     <= state_d;
      sync_run_q  <= sync_run_d;
      byte_cnt_q  <= byte_cnt_d;
      inact_q     <= inact_d;
      start_acc_q <= start_acc_d;
      offs_acc_q  <= offs_acc_d;
      cnt_acc_q   <= cnt_acc_d;
      if (cfg_we_i) begin
        type_bit_q <= cfg_wdata_i;
      end
      if (in_acc && frame_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shift register and output payload
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    if (in_acc && frame_done) begin
      health_q    <= health;
      pay_q       <= frame_word;
      out_inact_q <= inact_d;
      start_tot_q <= start_wide[TOTAL_W-1:0];
      offs_tot_q  <= offs_wide[TOTAL_W-1:0];
      cnt_tot_q   <= cnt_wide[TOTAL_W-1:0];
    end
  end

  // Output word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = health_q;
  assign m_axis_tdata  = {2'b00, cnt_tot_q, offs_tot_q, start_tot_q, out_inact_q, pay_q,
                          pay_q[CHIP_LSB +: CHIP_W]};

  // Checks
  a_hunt_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HUNT |-> byte_cnt_q == 2'd0)
    else $error("byte count nonzero while hunting");

  a_sync_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_run_q != 2'd3)
    else $error("sync run count out of range");

  a_frame_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && frame_done |=> out_valid_q && state_q == ST_HUNT)
    else $error("completed frame did not produce a word");

  a_error_keeps_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && frame_done && !health |=>
      $stable(start_acc_q) && $stable(offs_acc_q) && $stable(cnt_acc_q) && $stable(inact_q))
    else $error("error packet changed health state");

  a_hunt_no_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HUNT |=> $stable(start_acc_q) && $stable(cnt_acc_q))
    else $error("totals changed while hunting");

endmodule
